// ===== rtl/rcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared widths, command codes and controller/datapath interface structs for
// the rod cutting solver.
// ----------------------------------------------------------------------------
package rcd_pkg;

    localparam int LEN_W   = 7;
    localparam int PRICE_W = 16;
    localparam int REV_W   = 22;
    localparam int SUM_W   = REV_W + 1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    typedef struct packed {
        logic load;         // write one price
        logic solve_start;  // latch rod length, reset counters
        logic issue;        // read price[k-1] and revenue[len-k], step k
        logic len_next;     // store best for len, step len
        logic emit;         // send one piece of the decomposition
        logic emit_zero;    // empty rod result
    } t_dp_cmd;

    typedef struct packed {
        logic n_zero;
        logic k_last;
        logic len_last;
        logic emit_done;
    } t_dp_stat;

endpackage

// ===== rtl/rod_cutting_with_decomposition_top.sv =====
// Load request: written while idle, busy stays low, no result.
// Solve request for length n (n > 0): busy rises, the fill makes one add-compare step
// per (len, k) pair, and the n or fewer results come out back to back at the end.
// Rod length 0: a single result, raised from the setup state. Results cannot be stalled.
// Reset is synchronous, active low, clears control only; tables stay undefined until written.
// ----------------------------------------------------------------------------
// rod_cutting_with_decomposition_top
// Bottom-up rod cutting solver with price table load and decomposition
// output, one piece per result strobe.
// ----------------------------------------------------------------------------
module rod_cutting_with_decomposition_top #(
    parameter int MAX_LEN = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_cmd,
    input  logic [rcd_pkg::LEN_W-1:0]   i_piece_len_in,
    input  logic [rcd_pkg::PRICE_W-1:0] i_price,
    input  logic [rcd_pkg::LEN_W-1:0]   i_rod_len,
    output logic                        o_valid,
    output logic [rcd_pkg::REV_W-1:0]   o_best_revenue,
    output logic [rcd_pkg::LEN_W-1:0]   o_piece_len,
    output logic                        o_last
);

    rcd_pkg::t_dp_cmd  dp_cmd;
    rcd_pkg::t_dp_stat dp_stat;

    rcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_stat   (dp_stat),
        .busy     (busy),
        .o_dp_cmd (dp_cmd)
    );

    rcd_dpath #(
        .MAX_LEN (MAX_LEN)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dp_cmd       (dp_cmd),
        .o_stat         (dp_stat),
        .i_piece_len_in (i_piece_len_in),
        .i_price        (i_price),
        .i_rod_len      (i_rod_len),
        .o_valid        (o_valid),
        .o_best_revenue (o_best_revenue),
        .o_piece_len    (o_piece_len),
        .o_last         (o_last)
    );

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("busy still high on final result");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (busy && o_piece_len != '0))
        else $error("non-final result with idle block or empty piece");

    a_solve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == rcd_pkg::CMD_SOLVE) |=> busy)
        else $error("solve request did not raise busy");

    a_piece_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_piece_len <= rcd_pkg::LEN_W'(MAX_LEN)))
        else $error("piece length out of range");

endmodule

// ===== rtl/rcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcd_ctrl
// Sequencer for the solver: accepts requests, walks the fill loop over
// (len, k) and the decomposition walk through the datapath.
// ----------------------------------------------------------------------------
module rcd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_cmd,
    input  rcd_pkg::t_dp_stat i_stat,
    output logic             busy,
    output rcd_pkg::t_dp_cmd o_dp_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_FILL,
        S_DRAIN,
        S_WRITE,
        S_PRIME,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_busy;

    assign busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start && i_cmd == rcd_pkg::CMD_SOLVE) begin
                        r_state <= S_SETUP;
                        r_busy  <= 1'b1;
                    end
                end
                S_SETUP: begin
                    if (i_stat.n_zero) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end else begin
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (i_stat.k_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                // last candidate is compared at the end of this cycle
                S_DRAIN: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (i_stat.len_last) begin
                        r_state <= S_PRIME;
                    end else begin
                        r_state <= S_FILL;
                    end
                end
                S_PRIME: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_stat.emit_done) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_dp_cmd             = '0;
        o_dp_cmd.load        = (r_state == S_IDLE) && start && (i_cmd == rcd_pkg::CMD_LOAD);
        o_dp_cmd.solve_start = (r_state == S_IDLE) && start && (i_cmd == rcd_pkg::CMD_SOLVE);
        o_dp_cmd.issue       = (r_state == S_FILL);
        o_dp_cmd.len_next    = (r_state == S_WRITE);
        o_dp_cmd.emit        = (r_state == S_EMIT);
        o_dp_cmd.emit_zero   = (r_state == S_SETUP) && i_stat.n_zero;
    end

endmodule

// ===== rtl/rcd_dpath.sv =====
// ----------------------------------------------------------------------------
// rcd_dpath
// Price, revenue and first-cut tables, loop counters, the add-compare unit
// and the result registers.
// ----------------------------------------------------------------------------
module rcd_dpath #(
    parameter int MAX_LEN = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rcd_pkg::t_dp_cmd            i_dp_cmd,
    output rcd_pkg::t_dp_stat           o_stat,
    input  logic [rcd_pkg::LEN_W-1:0]   i_piece_len_in,
    input  logic [rcd_pkg::PRICE_W-1:0] i_price,
    input  logic [rcd_pkg::LEN_W-1:0]   i_rod_len,
    output logic                        o_valid,
    output logic [rcd_pkg::REV_W-1:0]   o_best_revenue,
    output logic [rcd_pkg::LEN_W-1:0]   o_piece_len,
    output logic                        o_last
);

    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int PAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [rcd_pkg::PRICE_W-1:0] r_price_mem [MAX_LEN];
    logic [rcd_pkg::REV_W-1:0]   r_rev_mem   [MAX_LEN+1];
    logic [LW-1:0]               r_cut_mem   [MAX_LEN+1];

    logic [rcd_pkg::PRICE_W-1:0] r_price_q;
    logic [rcd_pkg::REV_W-1:0]   r_rev_q;
    logic [LW-1:0]               r_cut_q;

    logic [LW-1:0] r_n;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_k;
    logic [LW-1:0] r_k_d;
    logic [LW-1:0] r_rem;
    logic          r_rev_zero;
    logic          r_acc_first;
    logic          r_acc_vld;
    logic [rcd_pkg::SUM_W-1:0] r_best;
    logic [LW-1:0]             r_cut_best;

    logic                        r_o_valid;
    logic [rcd_pkg::REV_W-1:0]   r_o_rev;
    logic [rcd_pkg::LEN_W-1:0]   r_o_piece;
    logic                        r_o_last;

    logic                        plen_ok;
    logic [PAW-1:0]              load_addr;
    logic [LW-1:0]               n_sat;
    logic [rcd_pkg::SUM_W-1:0]   cand;
    logic [LW-1:0]               piece;
    logic [LW-1:0]               rem_next;
    logic [LW-1:0]               cut_raddr;

    assign plen_ok   = (i_piece_len_in != '0) &&
                       (i_piece_len_in <= rcd_pkg::LEN_W'(MAX_LEN));
    assign load_addr = PAW'(i_piece_len_in - rcd_pkg::LEN_W'(1));
    assign n_sat     = (i_rod_len > rcd_pkg::LEN_W'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(i_rod_len);

    // revenue of a zero-length remainder is always 0
    assign cand = rcd_pkg::SUM_W'(r_price_q) +
                  (r_rev_zero ? '0 : rcd_pkg::SUM_W'(r_rev_q));

    assign piece     = (r_cut_q == '0 || r_cut_q > r_rem) ? r_rem : r_cut_q;
    assign rem_next  = r_rem - piece;
    // during the walk the next address comes straight from this piece
    assign cut_raddr = i_dp_cmd.emit ? rem_next : r_rem;

    assign o_stat.n_zero    = (r_n == '0);
    assign o_stat.k_last    = (r_k == r_len);
    assign o_stat.len_last  = (r_len == r_n);
    assign o_stat.emit_done = (rem_next == '0);

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load && plen_ok) begin
            r_price_mem[load_addr] <= i_price;
        end
        if (i_dp_cmd.len_next) begin
            r_rev_mem[r_len] <= r_best[rcd_pkg::REV_W-1:0];
            r_cut_mem[r_len] <= r_cut_best;
        end
        r_price_q <= r_price_mem[PAW'(r_k - LW'(1))];
        r_rev_q   <= r_rev_mem[r_len - r_k];
        r_cut_q   <= r_cut_mem[cut_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.solve_start) begin
            r_n   <= n_sat;
            r_len <= LW'(1);
            r_k   <= LW'(1);
            r_rem <= n_sat;
        end
        if (i_dp_cmd.issue) begin
            r_k <= r_k + LW'(1);
        end
        if (i_dp_cmd.len_next) begin
            r_len <= r_len + LW'(1);
            r_k   <= LW'(1);
        end
        if (i_dp_cmd.emit) begin
            r_rem <= rem_next;
        end
        r_rev_zero  <= (r_k == r_len);
        r_acc_first <= (r_k == LW'(1));
        r_k_d       <= r_k;
        // strict compare keeps the shortest first piece on ties
        if (r_acc_vld && (r_acc_first || cand > r_best)) begin
            r_best     <= cand;
            r_cut_best <= r_k_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_acc_vld <= i_dp_cmd.issue;
            r_o_valid <= i_dp_cmd.emit || i_dp_cmd.emit_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.emit) begin
            r_o_rev   <= r_best[rcd_pkg::REV_W-1:0];
            r_o_piece <= rcd_pkg::LEN_W'(piece);
            r_o_last  <= (rem_next == '0);
        end else if (i_dp_cmd.emit_zero) begin
            r_o_rev   <= '0;
            r_o_piece <= '0;
            r_o_last  <= 1'b1;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_best_revenue = r_o_rev;
    assign o_piece_len    = r_o_piece;
    assign o_last         = r_o_last;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rod cutting solver. Price loads and solve
// requests are queued up front and driven with random gaps; a bottom-up
// revenue predictor builds the expected cut list for every solve, and a
// monitor compares each result strobe with the oldest expected piece.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_LEN   = 64;
    localparam int N_ITEMS   = 270;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        logic                        cmd;
        logic [rcd_pkg::LEN_W-1:0]   plen;
        logic [rcd_pkg::PRICE_W-1:0] price;
        logic [rcd_pkg::LEN_W-1:0]   rod;
        int                          gap;
        bit                          hold;   // wait for all pieces of earlier solves
    } t_rod_req;

    typedef struct {
        logic [rcd_pkg::REV_W-1:0] rev;
        logic [rcd_pkg::LEN_W-1:0] piece;
        logic                      is_last;
    } t_piece;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic                        i_cmd = rcd_pkg::CMD_LOAD;
    logic [rcd_pkg::LEN_W-1:0]   i_piece_len_in = '0;
    logic [rcd_pkg::PRICE_W-1:0] i_price = '0;
    logic [rcd_pkg::LEN_W-1:0]   i_rod_len = '0;
    logic                        o_valid;
    logic [rcd_pkg::REV_W-1:0]   o_best_revenue;
    logic [rcd_pkg::LEN_W-1:0]   o_piece_len;
    logic                        o_last;

    rod_cutting_with_decomposition_top #(
        .MAX_LEN(MAX_LEN)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_piece_len_in (i_piece_len_in),
        .i_price        (i_price),
        .i_rod_len      (i_rod_len),
        .o_valid        (o_valid),
        .o_best_revenue (o_best_revenue),
        .o_piece_len    (o_piece_len),
        .o_last         (o_last)
    );

    // predictor state
    logic [rcd_pkg::PRICE_W-1:0] price_tbl [MAX_LEN];
    logic [rcd_pkg::REV_W-1:0]   rev_tbl   [MAX_LEN+1];
    logic [rcd_pkg::LEN_W-1:0]   cut_tbl   [MAX_LEN+1];

    t_rod_req pending_q[$];
    t_piece   cut_q[$];
    t_rod_req staged_req;
    bit       staged = 1'b0;
    int       gap_left = 0;
    int       calm_left = 0;

    int n_queued = 0;
    int n_accepted = 0;
    int n_loads = 0;
    int n_solves = 0;
    int n_checked = 0;
    int n_fail = 0;
    int longest_rod = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d of %0d requests accepted, %0d pieces outstanding",
                 n_accepted, n_queued, cut_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void flag(string what);
        n_fail++;
        if (n_fail <= MAX_SHOWN) begin
            $display("ERROR @%0t: %s", $time, what);
        end
    endfunction

    // Queue one request; idle gaps come in random lengths with calm stretches.
    function automatic void add_req(logic cmd, logic [rcd_pkg::LEN_W-1:0] plen,
                                    logic [rcd_pkg::PRICE_W-1:0] price,
                                    logic [rcd_pkg::LEN_W-1:0] rod, bit hold);
        t_rod_req r;
        if (calm_left == 0 && $urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(5, 20);
        end
        r.cmd   = cmd;
        r.plen  = plen;
        r.price = price;
        r.rod   = rod;
        r.hold  = hold;
        r.gap   = (calm_left > 0) ? 0 : $urandom_range(0, 8);
        if (calm_left > 0) begin
            calm_left--;
        end
        pending_q.push_back(r);
        n_queued++;
    endfunction

    function automatic void load_price(int plen, int price);
        add_req(rcd_pkg::CMD_LOAD, rcd_pkg::LEN_W'(plen), rcd_pkg::PRICE_W'(price),
                rcd_pkg::LEN_W'($urandom), 1'b0);
    endfunction

    function automatic void solve_rod(int rod, bit hold);
        add_req(rcd_pkg::CMD_SOLVE, rcd_pkg::LEN_W'($urandom), rcd_pkg::PRICE_W'($urandom),
                rcd_pkg::LEN_W'(rod), hold);
    endfunction

    // Bottom-up revenue fill, then walk the first-cut table to list the pieces.
    function automatic void apply_request(t_rod_req r);
        int                        n;
        int                        remain;
        int                        piece;
        logic [rcd_pkg::SUM_W-1:0] best;
        logic [rcd_pkg::SUM_W-1:0] cand;
        logic [rcd_pkg::LEN_W-1:0] first;
        t_piece                    p;
        if (r.cmd == rcd_pkg::CMD_LOAD) begin
            n_loads++;
            if (r.plen >= 1 && r.plen <= MAX_LEN) begin
                price_tbl[r.plen - 1] = r.price;
            end
        end else begin
            n_solves++;
            n = (r.rod > MAX_LEN) ? MAX_LEN : int'(r.rod);
            if (n > longest_rod) begin
                longest_rod = n;
            end
            if (n == 0) begin
                p.rev     = '0;
                p.piece   = '0;
                p.is_last = 1'b1;
                cut_q.push_back(p);
            end else begin
                rev_tbl[0] = '0;
                cut_tbl[0] = '0;
                for (int len = 1; len <= n; len++) begin
                    best  = price_tbl[0] + rev_tbl[len - 1];
                    first = rcd_pkg::LEN_W'(1);
                    for (int k = 2; k <= len; k++) begin
                        cand = price_tbl[k - 1] + rev_tbl[len - k];
                        // strict compare: ties keep the shorter first piece
                        if (cand > best) begin
                            best  = cand;
                            first = rcd_pkg::LEN_W'(k);
                        end
                    end
                    rev_tbl[len] = best[rcd_pkg::REV_W-1:0];
                    cut_tbl[len] = first;
                end
                remain = n;
                while (remain > 0) begin
                    piece = cut_tbl[remain];
                    if (piece == 0 || piece > remain) begin
                        piece = remain;
                    end
                    remain   -= piece;
                    p.rev     = rev_tbl[n];
                    p.piece   = rcd_pkg::LEN_W'(piece);
                    p.is_last = (remain == 0);
                    cut_q.push_back(p);
                end
            end
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin : drv
        logic fire;
        logic nxt_start;
        fire      = start && !busy;
        nxt_start = start && !fire;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else begin
            if (fire) begin
                apply_request(staged_req);
                n_accepted++;
                staged = 1'b0;
            end
            if (!nxt_start) begin
                if (!staged && gap_left == 0 && pending_q.size() != 0) begin
                    staged_req = pending_q.pop_front();
                    gap_left   = staged_req.gap + 1;
                end
                if (gap_left > 1) begin
                    gap_left--;
                end else if (gap_left == 1 &&
                             (!staged_req.hold || (cut_q.size() == 0 && !busy))) begin
                    gap_left       = 0;
                    staged         = 1'b1;
                    i_cmd          <= staged_req.cmd;
                    i_piece_len_in <= staged_req.plen;
                    i_price        <= staged_req.price;
                    i_rod_len      <= staged_req.rod;
                    nxt_start      = 1'b1;
                end
            end
        end
        start <= nxt_start;
    end

    // result monitor
    always @(posedge i_clk) begin : mon
        t_piece want;
        if (i_rst_n && o_valid) begin
            if (cut_q.size() == 0) begin
                flag($sformatf("unexpected piece: revenue %0d piece %0d last %0b",
                               o_best_revenue, o_piece_len, o_last));
            end else begin
                want = cut_q.pop_front();
                n_checked++;
                if (o_best_revenue !== want.rev || o_piece_len !== want.piece ||
                    o_last !== want.is_last) begin
                    flag($sformatf({"piece %0d: revenue exp %0d got %0d, ",
                                    "piece exp %0d got %0d, last exp %0b got %0b"},
                                   n_checked, want.rev, o_best_revenue,
                                   want.piece, o_piece_len, want.is_last, o_last));
                end
            end
        end
    end

    // stimulus and end of run
    initial begin : stim
        int base;
        int sel;
        int drain;
        // directed: empty rod, bad lengths, ties, price extremes
        solve_rod(0, 1'b0);
        load_price(0, 16'hFFFF);
        load_price(127, 16'hFFFF);
        for (int i = 1; i <= 4; i++) begin
            load_price(i, 10 * i);
        end
        solve_rod(4, 1'b0);          // all splits tie: four unit pieces
        load_price(2, 25);
        solve_rod(4, 1'b0);
        load_price(3, 16'hFFFF);
        solve_rod(3, 1'b0);
        solve_rod(4, 1'b0);          // 1+3 ties 3+1, shorter first wins
        load_price(1, 0);
        solve_rod(1, 1'b0);
        load_price(1, 16'hFFFF);
        solve_rod(2, 1'b0);
        load_price(64, 0);
        solve_rod(0, 1'b1);

        // fill the whole table with linear prices: every cut ties
        base = $urandom_range(1, 1023);
        for (int i = 1; i <= MAX_LEN; i++) begin
            load_price(i, i * base);
        end
        solve_rod(127, 1'b1);        // saturates, 64 unit pieces

        while (n_queued < N_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 5) begin
                // noise: out-of-range length, ignored by the block
                load_price(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 127),
                           $urandom);
            end else if (sel < 50) begin
                if ($urandom_range(0, 15) == 0) begin
                    base = $urandom_range(1, 1023);
                end
                sel = $urandom_range(0, 9);
                if (sel < 4) begin
                    load_price($urandom_range(1, 8), 0);
                    n_queued--;
                    pending_q[pending_q.size() - 1].plen  =
                        rcd_pkg::LEN_W'($urandom_range(1, 64));
                    pending_q[pending_q.size() - 1].price =
                        rcd_pkg::PRICE_W'(pending_q[pending_q.size() - 1].plen * base);
                    n_queued++;
                end else if (sel < 8) begin
                    load_price($urandom_range(1, 64), $urandom);
                end else begin
                    load_price($urandom_range(1, 64),
                               ($urandom_range(0, 1) == 0) ? 0 : 16'hFFFF);
                end
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 80) begin
                    solve_rod($urandom_range(0, 12), $urandom_range(0, 29) == 0);
                end else if (sel < 95) begin
                    solve_rod($urandom_range(13, 40), 1'b0);
                end else begin
                    solve_rod($urandom_range(41, 127), 1'b0);
                end
            end
        end

        while (n_accepted < n_queued) begin
            @(posedge i_clk);
        end
        drain = 0;
        while ((cut_q.size() != 0 || busy) && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (64) @(posedge i_clk);
        if (cut_q.size() != 0) begin
            flag($sformatf("%0d expected pieces never arrived", cut_q.size()));
        end

        $display("run covered %0d requests: %0d price loads, %0d solves up to length %0d",
                 n_accepted, n_loads, n_solves, longest_rod);
        $display("%0d result pieces checked, %0d failures", n_checked, n_fail);
        if (n_fail == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
